FILE: src/arc_center_from_radius_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the arc center core
// Short forms for concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARC_CENTER_FROM_RADIUS_CORE_MACROS_SVH
`define ARC_CENTER_FROM_RADIUS_CORE_MACROS_SVH

// Same-cycle implication check
`define ACFR_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define ACFR_CHECK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/acfr_pkg.sv
// ----------------------------------------------------------------------------
// acfr_pkg
// Shared types and constants of the radius-mode arc center core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acfr_pkg;

  // Default fraction bits of the coordinate format
  localparam int ACFR_FRAC_BITS = 16;
  // Coordinate width
  localparam int ACFR_COORD_W   = 32;
  // Chord and radius difference width
  localparam int ACFR_DIFF_W    = 33;
  // Quotient bits of dx*|h| and dy*|h|
  localparam int ACFR_QUOT_W    = 34;

  typedef enum logic [1:0] {
    ACFR_ST_OK    = 2'd0,
    ACFR_ST_SHORT = 2'd1,
    ACFR_ST_ZERO  = 2'd2
  } acfr_status_t;

  // Side data that travels with each beat down the pipeline
  typedef struct packed {
    logic signed [ACFR_COORD_W-1:0] sx;
    logic signed [ACFR_COORD_W-1:0] sy;
    logic signed [ACFR_DIFF_W-1:0]  dx;
    logic signed [ACFR_DIFF_W-1:0]  dy;
    logic [ACFR_DIFF_W-1:0]         adx;
    logic [ACFR_DIFF_W-1:0]         ady;
    logic                           gneg;
    acfr_status_t                   status;
  } acfr_pl_t;

endpackage

FILE: src/acfr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// acfr_sqrt_cell
// One digit step of a pipelined integer square root: one root bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acfr_sqrt_cell #(
  parameter int RW = 49
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] x_in,
  input  logic [RW+1:0]   rem_in,
  input  logic [RW-1:0]   root_in,
  output logic [2*RW-1:0] x_out,
  output logic [RW+1:0]   rem_out,
  output logic [RW-1:0]   root_out
);

  logic [2*RW-1:0] x_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [RW+1:0]   cand;
  logic [RW+1:0]   trial;
  logic            ge;

  // Bring down the next bit pair and try the next root bit
  always_comb begin
    cand  = {rem_in[RW-1:0], x_in[2*RW-1 -: 2]};
    trial = {root_in, 2'b01};
    ge    = (cand >= trial);
  end

  // Advance one step
  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= {x_in[2*RW-3:0], 2'b00};
      rem_r  <= ge ? (cand - trial) : cand;
      root_r <= {root_in[RW-2:0], ge};
    end
  end

  assign x_out    = x_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;

endmodule

FILE: src/acfr_div_cell.sv
// ----------------------------------------------------------------------------
// acfr_div_cell
// One step of a pipelined restoring divider: one quotient bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acfr_div_cell #(
  parameter int RW = 49,
  parameter int QW = 34
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] dv_in,
  input  logic [QW-1:0] n_in,
  input  logic [RW-1:0] rem_in,
  input  logic [QW-1:0] q_in,
  output logic [QW-1:0] n_out,
  output logic [RW-1:0] rem_out,
  output logic [QW-1:0] q_out
);

  logic [QW-1:0] n_r;
  logic [RW-1:0] rem_r;
  logic [QW-1:0] q_r;
  logic [RW:0]   cand;
  logic [RW:0]   diff;
  logic          ge;

  // Shift in the next dividend bit and compare against the divisor
  always_comb begin
    cand = {rem_in, n_in[QW-1]};
    diff = cand - {1'b0, dv_in};
    ge   = (cand >= {1'b0, dv_in});
  end

  // Advance one step
  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= {n_in[QW-2:0], 1'b0};
      rem_r <= ge ? diff[RW-1:0] : cand[RW-1:0];
      q_r   <= {q_in[QW-2:0], ge};
    end
  end

  assign n_out   = n_r;
  assign rem_out = rem_r;
  assign q_out   = q_r;

endmodule

FILE: src/arc_center_from_radius_core.sv
// Throughput: one arc per cycle; the whole pipeline moves as one and holds
// while a result beat waits on out_ready.
// Depth is set by the two square-root cell rows (FRAC_BITS + 33 cells) and
// the two divider cell rows (34 cells).
// Reset clears the pipeline valid bits and the mode register to 0.
// ----------------------------------------------------------------------------
// arc_center_from_radius_core
// Radius-mode arc center: chord setup, square roots and divides as rows of
// cells, then rounding, offset and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arc_center_from_radius_core_macros.svh"

module arc_center_from_radius_core #(
  parameter int FRAC_BITS = acfr_pkg::ACFR_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_absolute_ijk_mode,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [acfr_pkg::ACFR_COORD_W-1:0] in_start_x,
  input  logic signed [acfr_pkg::ACFR_COORD_W-1:0] in_start_y,
  input  logic signed [acfr_pkg::ACFR_COORD_W-1:0] in_end_x,
  input  logic signed [acfr_pkg::ACFR_COORD_W-1:0] in_end_y,
  input  logic signed [acfr_pkg::ACFR_COORD_W-1:0] in_radius,
  input  logic                                in_clockwise,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [acfr_pkg::ACFR_COORD_W-1:0] out_center_x,
  output logic signed [acfr_pkg::ACFR_COORD_W-1:0] out_center_y,
  output logic [1:0]                          out_status
);

  import acfr_pkg::*;

  localparam int DW   = ACFR_DIFF_W;
  localparam int SQW  = 2 * DW;                 // squares and chord length^2
  localparam int RW   = DW + FRAC_BITS;         // root width of chord length
  localparam int XW   = 2 * RW;
  localparam int QW   = ACFR_QUOT_W;
  localparam int NUMW = DW + ACFR_COORD_W;      // |d| * s
  localparam int REM0W = NUMW - QW + FRAC_BITS;
  localparam int OW   = DW + 2;                 // offset width
  localparam int CW   = OW + 1;                 // center sum width
  localparam int NS   = RW + QW + 7;            // pipeline stages
  localparam int ST_SQ  = 3;                    // first square-root stage
  localparam int ST_MUL = RW + 3;
  localparam int ST_RND = RW + QW + 4;

  localparam logic signed [CW-1:0] SAT_HI = CW'((64'sd1 <<< (ACFR_COORD_W - 1)) - 1);
  localparam logic signed [CW-1:0] SAT_LO = -CW'(64'sd1 <<< (ACFR_COORD_W - 1));

  logic            mode_r;
  logic [NS-1:0]   vld_r;
  logic            adv;
  acfr_pl_t        pl_r [NS-1];
  acfr_pl_t        pl0;
  acfr_pl_t        pl2_nxt;

  logic signed [DW-1:0] dx_w, dy_w;
  logic [ACFR_COORD_W-1:0] absr_w;
  logic [DW-1:0]   twor_r;
  logic [SQW-1:0]  sqx_r, sqy_r, r4_r;
  logic [SQW-1:0]  d2_nxt;
  logic [SQW-1:0]  d2_r;
  logic [63:0]     q_r;
  acfr_status_t    st_nxt;

  logic [XW-1:0]   sd_x [RW+1];
  logic [RW+1:0]   sd_rem [RW+1];
  logic [RW-1:0]   sd_root [RW+1];
  logic [XW-1:0]   ss_x [RW+1];
  logic [RW+1:0]   ss_rem [RW+1];
  logic [RW-1:0]   ss_root [RW+1];

  logic [NUMW-1:0] numx_r, numy_r;
  logic [RW-1:0]   dq_r [QW+1];
  logic [QW-1:0]   vx_n [QW+1];
  logic [RW-1:0]   vx_rem [QW+1];
  logic [QW-1:0]   vx_q [QW+1];
  logic [QW-1:0]   vy_n [QW+1];
  logic [RW-1:0]   vy_rem [QW+1];
  logic [QW-1:0]   vy_q [QW+1];

  logic [QW-1:0]   tx_r, ty_r;
  logic            rnd_x, rnd_y;
  logic            ok_rnd;
  logic signed [OW:0]   ex_w, ey_w;
  logic signed [OW-1:0] ox_r, oy_r;
  logic signed [CW-1:0] cx_w, cy_w;
  logic signed [ACFR_COORD_W-1:0] cx_r, cy_r;
  acfr_status_t    st_out_r;
  acfr_pl_t        pl_sum;
  acfr_pl_t        pl_out;

  // Mode register: written only while idle
  assign cfg_ready = ~|vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_absolute_ijk_mode;
    end
  end

  // Pipeline moves as one; hold everything while the result beat waits
  assign adv       = !vld_r[NS-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // Stage 0: chord and radius magnitudes
  always_comb begin
    dx_w   = DW'(in_end_x) - DW'(in_start_x);
    dy_w   = DW'(in_end_y) - DW'(in_start_y);
    absr_w = in_radius[ACFR_COORD_W-1] ? (~in_radius + 1'b1) : in_radius;
    pl0.sx     = in_start_x;
    pl0.sy     = in_start_y;
    pl0.dx     = dx_w;
    pl0.dy     = dy_w;
    pl0.adx    = dx_w[DW-1] ? (~dx_w + 1'b1) : dx_w;
    pl0.ady    = dy_w[DW-1] ? (~dy_w + 1'b1) : dy_w;
    pl0.gneg   = in_clockwise ^ in_radius[ACFR_COORD_W-1];
    pl0.status = ACFR_ST_OK;
  end

  // Stage 2: chord length^2, radius test and 4R^2 - d^2
  always_comb begin
    d2_nxt = sqx_r + sqy_r;
    priority if (d2_nxt == '0) begin
      st_nxt = ACFR_ST_ZERO;
    end else if (d2_nxt > r4_r) begin
      st_nxt = ACFR_ST_SHORT;
    end else begin
      st_nxt = ACFR_ST_OK;
    end
    pl2_nxt        = pl_r[1];
    pl2_nxt.status = st_nxt;
  end

  // Side data and the fixed front stages
  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r[0] <= pl0;
      pl_r[1] <= pl_r[0];
      pl_r[2] <= pl2_nxt;
      for (int i = 3; i < NS - 1; i++) begin
        pl_r[i] <= pl_r[i-1];
      end
      twor_r <= {absr_w, 1'b0};
      sqx_r  <= pl_r[0].adx * pl_r[0].adx;
      sqy_r  <= pl_r[0].ady * pl_r[0].ady;
      r4_r   <= twor_r * twor_r;
      d2_r   <= d2_nxt;
      q_r    <= (st_nxt == ACFR_ST_OK) ? 64'(r4_r - d2_nxt) : '0;
    end
  end

  // Square-root rows: chord length with extra fraction bits, and sqrt(4R^2-d^2)
  assign sd_x[0]    = {d2_r, {(2*FRAC_BITS){1'b0}}};
  assign sd_rem[0]  = '0;
  assign sd_root[0] = '0;
  assign ss_x[0]    = {{(XW-64){1'b0}}, q_r};
  assign ss_rem[0]  = '0;
  assign ss_root[0] = '0;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    acfr_sqrt_cell #(.RW(RW)) u_sd (
      .clk(clk), .en(adv),
      .x_in(sd_x[k]), .rem_in(sd_rem[k]), .root_in(sd_root[k]),
      .x_out(sd_x[k+1]), .rem_out(sd_rem[k+1]), .root_out(sd_root[k+1])
    );
    acfr_sqrt_cell #(.RW(RW)) u_ss (
      .clk(clk), .en(adv),
      .x_in(ss_x[k]), .rem_in(ss_rem[k]), .root_in(ss_root[k]),
      .x_out(ss_x[k+1]), .rem_out(ss_rem[k+1]), .root_out(ss_root[k+1])
    );
  end

  // Dividends |dx|*s and |dy|*s; hand the divisor down with the divider row
  always_ff @(posedge clk) begin
    if (adv) begin
      numx_r   <= pl_r[ST_MUL-1].adx * ss_root[RW][ACFR_COORD_W-1:0];
      numy_r   <= pl_r[ST_MUL-1].ady * ss_root[RW][ACFR_COORD_W-1:0];
      dq_r[0]  <= sd_root[RW];
      for (int j = 1; j <= QW; j++) begin
        dq_r[j] <= dq_r[j-1];
      end
    end
  end

  // Divider rows: (|d|*s << FRAC_BITS) / chord length
  assign vx_rem[0] = {{(RW-REM0W){1'b0}}, numx_r[NUMW-1:QW-FRAC_BITS]};
  assign vx_n[0]   = {numx_r[QW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign vx_q[0]   = '0;
  assign vy_rem[0] = {{(RW-REM0W){1'b0}}, numy_r[NUMW-1:QW-FRAC_BITS]};
  assign vy_n[0]   = {numy_r[QW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign vy_q[0]   = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    acfr_div_cell #(.RW(RW), .QW(QW)) u_vx (
      .clk(clk), .en(adv), .dv_in(dq_r[j]),
      .n_in(vx_n[j]), .rem_in(vx_rem[j]), .q_in(vx_q[j]),
      .n_out(vx_n[j+1]), .rem_out(vx_rem[j+1]), .q_out(vx_q[j+1])
    );
    acfr_div_cell #(.RW(RW), .QW(QW)) u_vy (
      .clk(clk), .en(adv), .dv_in(dq_r[j]),
      .n_in(vy_n[j]), .rem_in(vy_rem[j]), .q_in(vy_q[j]),
      .n_out(vy_n[j+1]), .rem_out(vy_rem[j+1]), .q_out(vy_q[j+1])
    );
  end

  // Round half away from zero; drop h on a short radius or zero chord
  always_comb begin
    rnd_x  = ({vx_rem[QW], 1'b0} >= {1'b0, dq_r[QW]});
    rnd_y  = ({vy_rem[QW], 1'b0} >= {1'b0, dq_r[QW]});
    ok_rnd = (pl_r[ST_RND-1].status == ACFR_ST_OK);
  end

  // Offsets: floor((dx - g*dy|h|)/2), floor((dy + g*dx|h|)/2)
  always_comb begin
    pl_sum = pl_r[ST_RND];
    if (pl_sum.gneg ^ pl_sum.dy[DW-1]) begin
      ex_w = (OW+1)'(pl_sum.dx) + (OW+1)'(ty_r);
    end else begin
      ex_w = (OW+1)'(pl_sum.dx) - (OW+1)'(ty_r);
    end
    if (pl_sum.gneg ^ pl_sum.dx[DW-1]) begin
      ey_w = (OW+1)'(pl_sum.dy) - (OW+1)'(tx_r);
    end else begin
      ey_w = (OW+1)'(pl_sum.dy) + (OW+1)'(tx_r);
    end
  end

  // Center or bare offset, saturated to the coordinate range
  always_comb begin
    pl_out = pl_r[NS-2];
    cx_w = mode_r ? CW'(ox_r) : (CW'(pl_out.sx) + CW'(ox_r));
    cy_w = mode_r ? CW'(oy_r) : (CW'(pl_out.sy) + CW'(oy_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r <= ok_rnd ? (vx_q[QW] + QW'(rnd_x)) : '0;
      ty_r <= ok_rnd ? (vy_q[QW] + QW'(rnd_y)) : '0;
      ox_r <= ex_w[OW:1];
      oy_r <= ey_w[OW:1];
      priority if (cx_w > SAT_HI) begin
        cx_r <= SAT_HI[ACFR_COORD_W-1:0];
      end else if (cx_w < SAT_LO) begin
        cx_r <= SAT_LO[ACFR_COORD_W-1:0];
      end else begin
        cx_r <= cx_w[ACFR_COORD_W-1:0];
      end
      priority if (cy_w > SAT_HI) begin
        cy_r <= SAT_HI[ACFR_COORD_W-1:0];
      end else if (cy_w < SAT_LO) begin
        cy_r <= SAT_LO[ACFR_COORD_W-1:0];
      end else begin
        cy_r <= cy_w[ACFR_COORD_W-1:0];
      end
      st_out_r <= pl_out.status;
    end
  end

  assign out_center_x = cx_r;
  assign out_center_y = cy_r;
  assign out_status   = st_out_r;

  // Checks
  `ACFR_CHECK(a_zero_bare,
    out_valid && mode_r && (out_status == ACFR_ST_ZERO),
    (out_center_x == '0) && (out_center_y == '0),
    "zero chord in offset mode must give a zero offset")
  `ACFR_CHECK(a_flat_mid,
    vld_r[NS-2] && (pl_r[NS-2].status != ACFR_ST_OK),
    (ox_r == (OW'(pl_r[NS-2].dx) >>> 1)) && (oy_r == (OW'(pl_r[NS-2].dy) >>> 1)),
    "clamped h must give the chord midpoint")
  `ACFR_CHECK(a_root_fit,
    vld_r[ST_MUL-1] && (pl_r[ST_MUL-1].status == ACFR_ST_OK),
    ss_root[RW][RW-1:ACFR_COORD_W] == '0,
    "radius root overflows the multiplier input")
  `ACFR_CHECK_NXT(a_hold,
    rst_n && !adv,
    $stable(vld_r) && $stable(out_center_x) && $stable(out_status),
    "pipeline moved while the result beat was stalled")

endmodule

FILE: tb/tb_arc_center_from_radius_core.sv
// ----------------------------------------------------------------------------
// tb_arc_center_from_radius_core
// Self-checking bench for the radius-mode arc center core: arc beats are
// driven with random gaps, every accepted beat is run through an exact
// integer predictor, and each result beat is compared against the oldest
// predicted center. Covers both mode settings, special cases and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_arc_center_from_radius_core;
  import acfr_pkg::*;

  localparam int  FB        = ACFR_FRAC_BITS;
  localparam int  DRAIN_CYC = 120;
  localparam int  LIMIT_CYC = 600000;

  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    acfr_status_t       st;
  } center_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_absolute_ijk_mode = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_start_x = '0;
  logic signed [31:0] in_start_y = '0;
  logic signed [31:0] in_end_x = '0;
  logic signed [31:0] in_end_y = '0;
  logic signed [31:0] in_radius = '0;
  logic in_clockwise = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_center_x;
  logic signed [31:0] out_center_y;
  logic [1:0] out_status;

  center_t center_q[$];
  logic    bare_mode = 1'b0;
  bit      idle_on = 1'b1;
  int      hold_req = 0;
  int      mismatches = 0;
  int      cycles = 0;

  arc_center_from_radius_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_absolute_ijk_mode(cfg_absolute_ijk_mode),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .in_radius(in_radius), .in_clockwise(in_clockwise),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_status(out_status)
  );

  always #5 clk = ~clk;

  // Integer square root, floor
  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= x) r = c;
    end
    return r[63:0];
  endfunction

  // Quotient rounded half away from zero (operands non-negative)
  function automatic logic [127:0] div_round(logic [127:0] n, logic [127:0] d);
    logic [127:0] quo;
    logic [127:0] rem;
    quo = n / d;
    rem = n % d;
    if (rem >= d - rem) quo = quo + 1;
    return quo;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Exact arc center for one command
  function automatic center_t arc_center(logic signed [31:0] sx, logic signed [31:0] sy,
                                         logic signed [31:0] ex, logic signed [31:0] ey,
                                         logic signed [31:0] rad, logic cw, logic bare);
    logic signed [33:0] dx, dy, r34;
    logic [33:0] adx, ady, twor;
    logic [127:0] d2, r4, s, dq, tx, ty;
    logic signed [63:0] stx, sty, ox, oy, wx, wy;
    logic gneg;
    center_t res;
    dx = ex - sx;
    dy = ey - sy;
    r34 = rad;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    twor = (r34 < 0 ? -r34 : r34) * 2;
    d2 = adx * adx + ady * ady;
    r4 = twor * twor;
    wx = dx;
    wy = dy;
    if (d2 == 0) begin
      res.st = ACFR_ST_ZERO;
      ox = 0;
      oy = 0;
    end else if (d2 > r4) begin
      res.st = ACFR_ST_SHORT;
      ox = wx >>> 1;
      oy = wy >>> 1;
    end else begin
      res.st = ACFR_ST_OK;
      s  = isqrt(r4 - d2);
      dq = isqrt(d2 << (2 * FB));
      tx = div_round((adx * s) << FB, dq);
      ty = div_round((ady * s) << FB, dq);
      stx = dx < 0 ? -$signed(tx[63:0]) : $signed(tx[63:0]);
      sty = dy < 0 ? -$signed(ty[63:0]) : $signed(ty[63:0]);
      gneg = cw != (rad < 0);
      ox = gneg ? (wx + sty) >>> 1 : (wx - sty) >>> 1;
      oy = gneg ? (wy - stx) >>> 1 : (wy + stx) >>> 1;
    end
    if (!bare) begin
      ox = ox + 64'(sx);
      oy = oy + 64'(sy);
    end
    res.cx = clip32(ox);
    res.cy = clip32(oy);
    return res;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    if (!idle_on) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one arc beat and record its predicted center on acceptance
  task automatic send_arc(logic signed [31:0] sx, logic signed [31:0] sy,
                          logic signed [31:0] ex, logic signed [31:0] ey,
                          logic signed [31:0] rad, logic cw);
    int g;
    g = pick_gap();
    repeat (g) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    in_radius <= rad;
    in_clockwise <= cw;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    center_q.push_back(arc_center(sx, sy, ex, ey, rad, cw, bare_mode));
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for the pipeline to empty, then write the mode register
  task automatic write_mode(logic m);
    drop_valid();
    wait (center_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
    cfg_absolute_ijk_mode <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    bare_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_rand_arc();
    int p, k;
    logic signed [31:0] sx, sy, dx, dy, rad;
    p = $urandom_range(0, 99);
    sx = $urandom;
    sy = $urandom;
    if (p < 70) begin
      // well-formed arc: chord within the diameter
      k = $urandom_range(2, 30);
      dx = $signed($urandom_range(0, (1 << k) - 1)) - (1 << (k - 1));
      dy = $signed($urandom_range(0, (1 << k) - 1)) - (1 << (k - 1));
      rad = $urandom_range(1 << k, (k >= 29) ? 32'h7fffffff : (1 << (k + 2)));
      if ($urandom_range(0, 1)) rad = -rad;
      if ($urandom_range(0, 3) == 0) begin
        sx = sx >>> $urandom_range(0, 31);
        sy = sy >>> $urandom_range(0, 31);
      end
      send_arc(sx, sy, sx + dx, sy + dy, rad, $urandom_range(0, 1));
    end else if (p < 85) begin
      send_arc(sx, sy, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    end else if (p < 93) begin
      send_arc(sx, sy, sx, sy, $urandom, $urandom_range(0, 1));
    end else begin
      // radius below half chord
      dx = $urandom_range(1000, 1 << 20);
      send_arc(sx, sy, sx + dx, sy - dx, $urandom_range(0, 999) - 500,
               $urandom_range(0, 1));
    end
  endtask

  task automatic test_directed();
    logic cw;
    for (int i = 0; i < 2; i++) begin
      cw = i[0];
      send_arc(0, 0, 0, 0, 0, cw);
      send_arc(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, cw);
      send_arc(0, 0, 32'sh10000, 0, 0, cw);
      send_arc(0, 0, 32'sh20000, 0, 32'sh10000, cw);
      send_arc(0, 0, 32'sh20000, 0, -32'sh10000, cw);
      send_arc(0, 0, 32'sh10000, 32'sh10000, 32'sh10000, cw);
      send_arc(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
               32'sh80000000, cw);
      send_arc(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
               32'sh7fffffff, cw);
      send_arc(32'sh7fff0000, 0, 32'sh7fff0000, 32'sh100, 32'sh7fffffff, cw);
      send_arc(32'sh80000000, 0, 32'sh80000000, 32'sh100, -32'sh7fffffff, cw);
      send_arc(-5, -3, 4, 7, 32'sh7fffffff, cw);
      send_arc(1, 0, 0, 0, 1, cw);
    end
  endtask

  task automatic test_random(int n);
    repeat (n) send_rand_arc();
  endtask

  // Receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req = 400;
    repeat (200) send_rand_arc();
    idle_on = 1'b1;
  endtask

  // Sender pauses until every result is back, then resumes
  task automatic test_drain_pause();
    repeat (50) send_rand_arc();
    drop_valid();
    wait (center_q.size() == 0);
    repeat (50) send_rand_arc();
  endtask

  // Result beat readiness with random stalls and requested hold-offs
  always @(negedge clk) begin : rx_ready
    static int stall_left = 0;
    int p;
    if (hold_req > 0) begin
      out_ready <= 1'b0;
      hold_req <= hold_req - 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (!idle_on) begin
      out_ready <= 1'b1;
    end else begin
      p = $urandom_range(0, 99);
      if (p < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = (p < 96) ? $urandom_range(0, 2) : $urandom_range(10, 50);
      end
    end
  end

  // Compare each result beat with the oldest predicted center
  always @(posedge clk) begin : result_check
    center_t e;
    if (rst_n && out_valid && out_ready) begin
      if (center_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: x=%0d y=%0d st=%0d",
                   out_center_x, out_center_y, out_status);
      end else begin
        e = center_q.pop_front();
        if (out_center_x !== e.cx || out_center_y !== e.cy || out_status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                     e.cx, e.cy, e.st, out_center_x, out_center_y, out_status);
        end
      end
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    write_mode(1'b1);
    test_directed();
    test_random(550);
    write_mode(1'b0);
    test_random(550);
    test_backpressure();
    test_drain_pause();
    write_mode(1'b1);
    test_random(300);
    write_mode(1'b0);
    test_random(100);
    drop_valid();
    wait (center_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && center_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
